FILE: design/lgt_pkg.sv
// lgt_pkg: types, constants and cell-rule functions for the life generation block.
// Shared by lgt_front, lgt_back and life_generation_torus. No dependencies.
package lgt_pkg;

	// Board geometry (stored rows and bits per row)
	localparam int NROWS    = 64;
	localparam int NCOLS    = 64;
	localparam int ROW_AW   = 6;
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int MIN_DIM  = 3;

	// Queue between front and back
	localparam int QDEPTH = 2;

	// Neighbour counts of the rule
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	// Command codes of the input transaction
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_TOGGLE  = 2'd1;
	localparam logic [1:0] CMD_ADVANCE = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	// Configuration register indexes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [5:0]  row_index;
		logic [5:0]  column_index;
		logic [63:0] row_bits;
	} item_t;

	typedef struct packed {
		logic [5:0]  out_row_index;
		logic [63:0] out_row_bits;
		logic        last_row;
	} result_t;

	typedef struct packed {
		logic [6:0] rows_in_use;
		logic [6:0] cols_in_use;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_TOGGLE,
		OP_ADVANCE
	} op_t;

	// Queue entry: for a toggle, bits holds the one-hot flip mask
	typedef struct packed {
		op_t         op;
		logic [5:0]  row;
		logic [63:0] bits;
	} qent_t;

	// Saturate a register value into MIN_DIM..limit
	function automatic logic [6:0] lgt_clamp(input logic [6:0] v, input logic [6:0] limit);
		logic [6:0] r;
		if (v < 7'(MIN_DIM))
			r = 7'(MIN_DIM);
		else if (v > limit)
			r = limit;
		else
			r = v;
		return r;
	endfunction

	// Ones in the columns in use
	function automatic logic [63:0] lgt_col_mask(input logic [6:0] c);
		logic [63:0] m;
		if (c >= 7'd64)
			m = '1;
		else
			m = (64'd1 << c) - 64'd1;
		return m;
	endfunction

	// Bit n holds column n-1, wrapping at c; w is already masked
	function automatic logic [63:0] lgt_from_left(input logic [63:0] w, input logic [6:0] c,
			input logic [63:0] m);
		logic [5:0] hi;
		hi = 6'(c - 7'd1);
		return ((w << 1) & m) | {63'd0, w[hi]};
	endfunction

	// Bit n holds column n+1, wrapping at c; w is already masked
	function automatic logic [63:0] lgt_from_right(input logic [63:0] w, input logic [6:0] c,
			input logic [63:0] m);
		logic [5:0] hi;
		hi = 6'(c - 7'd1);
		return ((w >> 1) | (64'(w[0]) << hi)) & m;
	endfunction

	// One new row from the old rows above, at and below it
	function automatic logic [63:0] lgt_next_row(input logic [63:0] up, input logic [63:0] mid,
			input logic [63:0] down, input logic [6:0] c, input logic [63:0] m);
		logic [63:0] ul, ur, ml, mr, dl, dr;
		logic [63:0] res;
		logic [3:0]  cnt;
		ul = lgt_from_left(up, c, m);
		ur = lgt_from_right(up, c, m);
		ml = lgt_from_left(mid, c, m);
		mr = lgt_from_right(mid, c, m);
		dl = lgt_from_left(down, c, m);
		dr = lgt_from_right(down, c, m);
		res = '0;
		for (int n = 0; n < NCOLS; n++) begin
			cnt = 4'(ul[n]) + 4'(up[n]) + 4'(ur[n]) + 4'(ml[n]) + 4'(mr[n])
				+ 4'(dl[n]) + 4'(down[n]) + 4'(dr[n]);
			res[n] = m[n] & ((cnt == BIRTH_COUNT) || (mid[n] && (cnt == SURVIVE_COUNT)));
		end
		return res;
	endfunction

endpackage

FILE: design/lgt_ram.sv
// lgt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lgt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: design/lgt_front.sv
// lgt_front: takes input transactions, decodes the command and queues work for the back end.
// Depends on lgt_pkg.
module lgt_front import lgt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t item,
	input  logic  item_valid,
	output logic  item_stall,
	output logic  q_valid,
	output qent_t q_entry,
	input  logic  q_pop
);

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	qent_t         fifo_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	qent_t         dec;
	logic          keep;
	logic          push;

	// Decode: toggles become a flip mask, the unused code is dropped
	always_comb begin
		dec.row  = item.row_index;
		dec.bits = item.row_bits;
		dec.op   = OP_LOAD;
		keep     = 1'b1;
		case (item.cmd)
			CMD_LOAD: begin
				dec.op = OP_LOAD;
			end
			CMD_TOGGLE: begin
				dec.op   = OP_TOGGLE;
				dec.bits = 64'd1 << item.column_index;
			end
			CMD_ADVANCE: begin
				dec.op = OP_ADVANCE;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign item_stall = (cnt_q == CW'(QDEPTH));
	assign push       = item_valid && !item_stall && keep;
	assign q_valid    = (cnt_q != '0);
	assign q_entry    = fifo_q[rd_ptr_q];

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (q_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			cnt_q <= cnt_q + CW'(push) - CW'(q_pop);
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= dec;
	end

endmodule

FILE: design/lgt_back.sv
// lgt_back: executes queued commands on the board RAM and sweeps generations row by row.
// Depends on lgt_pkg and lgt_ram.
module lgt_back import lgt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_valid,
	input  qent_t   q_entry,
	output logic    q_pop,
	output result_t result,
	output logic    result_valid,
	input  logic    result_stall
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_TOGGLE = 4'b0010,
		ST_SWEEP  = 4'b0100,
		ST_LAST   = 4'b1000
	} bstate_t;

	bstate_t           state_q, state_d;
	logic [6:0]        seq_q, seq_d;
	logic [NROWS-1:0]  row_valid_q;
	logic              rd_ok_q;
	logic [5:0]        tog_row_q;
	logic [63:0]       tog_bits_q;
	logic [63:0]       prev_q, mid_q, top_q;
	logic [63:0]       prev_d, mid_d, top_d;
	result_t           result_q;
	logic              result_valid_q;

	logic [6:0]        rows_eff, cols_eff;
	logic [63:0]       cmask;
	logic [5:0]        last_idx;
	logic [63:0]       rd_data, rd_word, cur, down, new_row;
	logic              out_free;
	logic              need_emit;
	logic              rd_en, wr_en;
	logic [ROW_AW-1:0] rd_addr, wr_addr;
	logic [63:0]       wr_data;
	logic              emit, emit_last;
	logic [5:0]        emit_row;

	lgt_ram #(
		.WIDTH(64),
		.DEPTH(NROWS)
	) u_board (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Effective geometry
	assign rows_eff = lgt_clamp(cfg.rows_in_use, 7'(MAX_ROWS));
	assign cols_eff = lgt_clamp(cfg.cols_in_use, 7'(MAX_COLS));
	assign cmask    = lgt_col_mask(cols_eff);
	assign last_idx = 6'(rows_eff - 7'd1);

	// Rows never written since reset read as dead
	assign rd_word   = rd_data & {64{rd_ok_q}};
	assign cur       = rd_word & cmask;
	assign down      = (state_q == ST_LAST) ? top_q : cur;
	assign new_row   = lgt_next_row(prev_q, mid_q, down, cols_eff, cmask);
	assign out_free  = !result_valid_q || !result_stall;
	assign need_emit = (seq_q >= 7'd2);
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	// Command sequencer: window of prev/mid rows, one RAM read per step
	always_comb begin
		state_d   = state_q;
		seq_d     = seq_q;
		prev_d    = prev_q;
		mid_d     = mid_q;
		top_d     = top_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = '0;
		emit      = 1'b0;
		emit_last = 1'b0;
		emit_row  = '0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_entry.op)
						OP_LOAD: begin
							wr_en   = 1'b1;
							wr_addr = q_entry.row;
							wr_data = q_entry.bits;
						end
						OP_TOGGLE: begin
							rd_en   = 1'b1;
							rd_addr = q_entry.row;
							state_d = ST_TOGGLE;
						end
						OP_ADVANCE: begin
							rd_en   = 1'b1;
							rd_addr = last_idx;
							seq_d   = '0;
							state_d = ST_SWEEP;
						end
						default: ;
					endcase
				end
			end
			ST_TOGGLE: begin
				wr_en   = 1'b1;
				wr_addr = tog_row_q;
				wr_data = rd_word ^ tog_bits_q;
				state_d = ST_IDLE;
			end
			ST_SWEEP: begin
				if (!need_emit || out_free) begin
					// read order: last row, then rows 0 .. last
					if (seq_q == 7'd0) begin
						prev_d = cur;
					end else if (seq_q == 7'd1) begin
						mid_d = cur;
						top_d = cur;
					end else begin
						emit     = 1'b1;
						emit_row = 6'(seq_q - 7'd2);
						wr_en    = 1'b1;
						wr_addr  = emit_row;
						wr_data  = new_row;
						prev_d   = mid_q;
						mid_d    = cur;
					end
					if (seq_q == rows_eff) begin
						state_d = ST_LAST;
					end else begin
						rd_en   = 1'b1;
						rd_addr = seq_q[5:0];
						seq_d   = seq_q + 7'd1;
					end
				end
			end
			ST_LAST: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					emit_row  = last_idx;
					wr_en     = 1'b1;
					wr_addr   = last_idx;
					wr_data   = new_row;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			seq_q          <= '0;
			row_valid_q    <= '0;
			rd_ok_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			seq_q   <= seq_d;
			if (wr_en)
				row_valid_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_ok_q <= row_valid_q[rd_addr];
			if (emit)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	// Row window, toggle operands and output register
	always_ff @(posedge clk) begin
		prev_q <= prev_d;
		mid_q  <= mid_d;
		top_q  <= top_d;
		if (q_pop) begin
			tog_row_q  <= q_entry.row;
			tog_bits_q <= q_entry.bits;
		end
		if (emit) begin
			result_q.out_row_index <= emit_row;
			result_q.out_row_bits  <= new_row;
			result_q.last_row      <= emit_last;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

FILE: design/life_generation_torus.sv
// life_generation_torus: top level of the toroidal life board, config registers and checks.
// Depends on lgt_pkg, lgt_front, lgt_back (and lgt_ram below it).
//
// Usage:
//   Input transactions (item_valid/item_stall, payload item) carry a command:
//   load a whole row, toggle one cell, or advance one generation. Loads and
//   toggles give no result. An advance emits one result transaction per row
//   in use (result_valid/result_stall, payload result), in row order, with
//   last_row set on the final one.
//   Commands pass through a two-entry queue into the back end, so the input
//   side keeps accepting while the back end is busy or the receiver stalls,
//   until both entries are taken; then item_stall stays high until one pops.
//   In the back end a load is a single write, a toggle a read, then a write,
//   and an advance a sweep through the single read port of the board RAM,
//   one row per cycle while the result side does not stall.
//   A stall on the result side holds the sweep in place; nothing is lost.
//   Reset empties the queue, marks every row dead and sets both geometry
//   registers to 64; no clearing pass is needed. The config port (cfg_valid,
//   cfg_ready, cfg_index, cfg_data) is always ready; write it only when idle.
module life_generation_torus import lgt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  logic       item_valid,
	output logic       item_stall,
	output result_t    result,
	output logic       result_valid,
	input  logic       result_stall,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data
);

	cfg_t  cfg_q;
	logic  q_valid;
	qent_t q_entry;
	logic  q_pop;

	assign cfg_ready = 1'b1;

	// Geometry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows_in_use <= 7'd64;
			cfg_q.cols_in_use <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROWS: cfg_q.rows_in_use <= cfg_data;
				REG_COLS: cfg_q.cols_in_use <= cfg_data;
				default: ;
			endcase
		end
	end

	lgt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop)
	);

	lgt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.q_pop       (q_pop),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

`ifndef NO_ASSERTIONS
	// The last-row mark sits on the row at the vertical wrap point
	a_last_row_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_row) |->
		(result.out_row_index == 6'(lgt_clamp(cfg_q.rows_in_use, 7'(MAX_ROWS)) - 7'd1)))
		else $error("last row mark on wrong row");

	// Emitted rows lie inside the rows in use
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
		({1'b0, result.out_row_index} < lgt_clamp(cfg_q.rows_in_use, 7'(MAX_ROWS))))
		else $error("emitted row outside rows in use");

	// No live cell beyond the columns in use
	a_cols_masked: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
		((result.out_row_bits &
		~lgt_col_mask(lgt_clamp(cfg_q.cols_in_use, 7'(MAX_COLS)))) == 64'd0))
		else $error("live cell beyond columns in use");
`endif

endmodule

FILE: verif/life_torus_checker.sv
// life_torus_checker: watches the item, result and config channels of life_generation_torus,
// keeps its own copy of the board, predicts each generation and compares the emitted rows.
// Depends on lgt_pkg for the payload types, command codes and register indexes.
module life_torus_checker import lgt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  logic       item_valid,
	input  logic       item_stall,
	input  result_t    result,
	input  logic       result_valid,
	input  logic       result_stall,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data,
	output int         mismatches,
	output int         pending_rows,
	output int         rows_checked
);

	// Shadow board and geometry registers
	logic [63:0] cells [NROWS];
	logic [6:0]  rows_reg;
	logic [6:0]  cols_reg;
	result_t     expected_rows [$];

	// Effective dimension: saturates into MIN_DIM..limit
	function automatic int clamp_dim(input logic [6:0] v, input int limit);
		if (int'(v) < MIN_DIM)
			return MIN_DIM;
		else if (int'(v) > limit)
			return limit;
		return int'(v);
	endfunction

	// Next generation on the torus; queues one expected row per row in use
	task automatic advance_generation();
		logic [63:0] old_rows [NROWS];
		logic [63:0] fresh;
		logic [63:0] in_use;
		result_t     exp_row;
		int          r, c, cnt, yy, xx;
		r = clamp_dim(rows_reg, MAX_ROWS);
		c = clamp_dim(cols_reg, MAX_COLS);
		in_use = (c >= 64) ? '1 : ((64'd1 << c) - 64'd1);
		// a generation sees only the old board, masked to the columns in use
		for (int i = 0; i < r; i++)
			old_rows[i] = cells[i] & in_use;
		for (int i = 0; i < r; i++) begin
			fresh = '0;
			for (int n = 0; n < c; n++) begin
				cnt = 0;
				for (int dy = -1; dy <= 1; dy++)
					for (int dx = -1; dx <= 1; dx++)
						if (dy != 0 || dx != 0) begin
							yy = (i + dy + r) % r;
							xx = (n + dx + c) % c;
							cnt += old_rows[yy][xx];
						end
				fresh[n] = (cnt == int'(BIRTH_COUNT))
					|| (old_rows[i][n] && cnt == int'(SURVIVE_COUNT));
			end
			cells[i] = fresh;
			exp_row.out_row_index = 6'(i);
			exp_row.out_row_bits  = fresh;
			exp_row.last_row      = (i == r - 1);
			expected_rows.push_back(exp_row);
		end
	endtask

	// Compare one result transaction with the oldest expected row
	task automatic check_row(input result_t got);
		result_t want;
		if (expected_rows.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: unexpected result: row %0d bits %h last %b",
					got.out_row_index, got.out_row_bits, got.last_row);
			return;
		end
		want = expected_rows.pop_front();
		rows_checked++;
		if (got.out_row_index !== want.out_row_index || got.out_row_bits !== want.out_row_bits
				|| got.last_row !== want.last_row) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: result %0d: expected row %0d bits %h last %b, got row %0d bits %h last %b",
					rows_checked, want.out_row_index, want.out_row_bits, want.last_row,
					got.out_row_index, got.out_row_bits, got.last_row);
		end
	endtask

	// Channel monitor: results first, then config, then the incoming item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NROWS; i++)
				cells[i] = '0;
			rows_reg = 7'(MAX_ROWS);
			cols_reg = 7'(MAX_COLS);
			expected_rows.delete();
			mismatches   = 0;
			rows_checked = 0;
			pending_rows = 0;
		end else begin
			if (result_valid && !result_stall)
				check_row(result);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ROWS)
					rows_reg = cfg_data;
				else
					cols_reg = cfg_data;
			end
			if (item_valid && !item_stall) begin
				case (item.cmd)
					CMD_LOAD: begin
						cells[item.row_index] = item.row_bits;
					end
					CMD_TOGGLE: begin
						cells[item.row_index][item.column_index] =
							~cells[item.row_index][item.column_index];
					end
					CMD_ADVANCE: begin
						advance_generation();
					end
					default: begin
						// unused code: no effect
					end
				endcase
			end
			pending_rows = expected_rows.size();
		end
	end

endmodule

FILE: verif/tb_life_generation_torus.sv
// tb_life_generation_torus: stimulus and verdict for life_generation_torus; checking is done
// by life_torus_checker. Depends on lgt_pkg, life_torus_checker and the block's RTL.
module tb_life_generation_torus;
	import lgt_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 20;
	localparam int TAIL_CYCLES   = 100;

	logic       clk;
	logic       arst_n;
	item_t      item;
	logic       item_valid;
	logic       item_stall;
	result_t    result;
	logic       result_valid;
	logic       result_stall;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_index;
	logic [6:0] cfg_data;

	int mismatches;
	int pending_rows;
	int rows_checked;
	int cycle_count;
	int items_sent;
	int generations_sent;
	int geometries;
	int burst_left;
	bit hold_req;
	bit steady;

	life_generation_torus DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	life_torus_checker generation_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending_rows (pending_rows),
		.rows_checked (rows_checked)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		cycle_count = 0;
		while (cycle_count <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d rows still expected", cycle_count, pending_rows);
		$display("Verification failed");
		$finish;
	end

	// Receiver: stall modes that change every so often, plus one long hold on request
	initial begin
		int       hold_left;
		int       mode_left;
		int       tick;
		bit [1:0] mode;
		result_stall = 1'b0;
		hold_left = 0;
		mode_left = 0;
		tick = 0;
		mode = 2'd0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode      = 2'($urandom_range(0, 3));
				mode_left = $urandom_range(30, 200);
			end
			mode_left--;
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				case (mode)
					2'd0: result_stall <= 1'b0;
					2'd1: result_stall <= ($urandom_range(0, 3) == 0);
					2'd2: result_stall <= ($urandom_range(0, 1) == 0);
					default: result_stall <= ((tick % 7) < 3);
				endcase
			end
		end
	end

	function automatic item_t make_item(input logic [1:0] code, input int row, input int col,
			input logic [63:0] bits);
		item_t t;
		t.cmd          = code;
		t.row_index    = 6'(row);
		t.column_index = 6'(col);
		t.row_bits     = bits;
		return t;
	endfunction

	// Random row contents at varying density
	function automatic logic [63:0] random_cells();
		logic [63:0] a, b, c;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return a;
			1: return a & b;
			2: return a & b & c;
			default: return a | b;
		endcase
	endfunction

	// Mostly rows in use, sometimes any stored row
	function automatic int pick_index(input int in_use);
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 63);
		return $urandom_range(0, in_use - 1);
	endfunction

	// One input transaction, then the burst/gap pattern of the sender
	task automatic send_item(input item_t t);
		item       <= t;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		items_sent++;
		if (t.cmd == CMD_ADVANCE)
			generations_sent++;
		@(negedge clk);
		if (!steady) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 8);
			end
		end
	endtask

	task automatic send_advance();
		send_item(make_item(CMD_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
			random_cells()));
	endtask

	// Wait until every expected row is in and the block has gone quiet
	task automatic drain();
		item_valid <= 1'b0;
		while (pending_rows != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write both geometry registers while the block is idle
	task automatic set_geometry(input logic [6:0] rows, input logic [6:0] cols);
		drain();
		cfg_index <= REG_ROWS;
		cfg_data  <= rows;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= REG_COLS;
		cfg_data  <= cols;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		geometries++;
	endtask

	// One geometry setting: an optional hold, then loads and toggles (mostly of rows in use) and generations
	task automatic run_phase(input logic [6:0] rows, input logic [6:0] cols, input int budget,
			input bit with_hold);
		int r_eff, c_eff, sent;
		set_geometry(rows, cols);
		r_eff = (rows < 7'd3) ? 3 : (rows > 7'd64) ? 64 : int'(rows);
		c_eff = (cols < 7'd3) ? 3 : (cols > 7'd64) ? 64 : int'(cols);
		sent = 0;
		// back pressure: receiver holds off while generations keep coming
		if (with_hold) begin
			hold_req = 1'b1;
			steady   = 1'b1;
			repeat (4) send_advance();
			steady = 1'b0;
			sent += 4;
			drain();
		end
		while (sent < budget) begin
			repeat ($urandom_range(1, (r_eff < 8) ? r_eff : 8)) begin
				send_item(make_item(CMD_LOAD, pick_index(r_eff), $urandom_range(0, 63),
					random_cells()));
				sent++;
			end
			repeat ($urandom_range(0, 3)) begin
				send_item(make_item(CMD_TOGGLE, pick_index(r_eff), pick_index(c_eff),
					random_cells()));
				sent++;
			end
			if ($urandom_range(0, 5) == 0)
				send_item(make_item(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
					random_cells()));
			repeat ($urandom_range(1, 3)) begin
				send_advance();
				sent++;
			end
		end
		drain();
	endtask

	// Stimulus and verdict
	initial begin
		item             = '0;
		item_valid       = 1'b0;
		cfg_valid        = 1'b0;
		cfg_index        = REG_ROWS;
		cfg_data         = '0;
		arst_n           = 1'b0;
		hold_req         = 1'b0;
		steady           = 1'b0;
		burst_left       = 0;
		items_sent       = 0;
		generations_sent = 0;
		geometries       = 1;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part on the reset geometry (64 x 64)
		send_advance();
		send_item(make_item(CMD_LOAD, 0, 0, '1));
		send_item(make_item(CMD_LOAD, 63, 63, '1));
		send_item(make_item(CMD_LOAD, 31, 17, 64'hA5A5_5A5A_0FF0_F00F));
		send_item(make_item(CMD_TOGGLE, 63, 63, '0));
		send_item(make_item(CMD_TOGGLE, 0, 0, '1));
		send_item(make_item(CMD_TOGGLE, 0, 63, '0));
		send_item(make_item(CMD_UNUSED, 63, 63, '1));
		send_advance();
		// glider across the column wrap
		send_item(make_item(CMD_LOAD, 20, 0, 64'h8000_0000_0000_0000));
		send_item(make_item(CMD_LOAD, 21, 0, 64'h0000_0000_0000_0001));
		send_item(make_item(CMD_LOAD, 22, 0, 64'hC000_0000_0000_0001));
		// blinker
		send_item(make_item(CMD_LOAD, 40, 0, '0));
		send_item(make_item(CMD_LOAD, 41, 0, 64'h7 << 30));
		send_item(make_item(CMD_LOAD, 42, 0, '0));
		send_advance();
		send_advance();
		drain();

		// Random part over several geometries, extremes and out-of-range values included
		run_phase(7'd0, 7'd127, 30, 1'b0);
		run_phase(7'd3, 7'd3, 30, 1'b0);
		run_phase(7'd2, 7'd1, 20, 1'b0);
		run_phase(7'($urandom_range(4, 12)), 7'($urandom_range(4, 63)), 30, 1'b0);
		run_phase(7'd127, 7'd5, 20, 1'b1);
		run_phase(7'($urandom_range(3, 10)), 7'd64, 40, 1'b0);
		run_phase(7'd64, 7'd65, 20, 1'b0);

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Covered %0d input transactions with %0d generations over %0d board geometries",
			items_sent, generations_sent, geometries);
		$display("%0d result rows compared, %0d mismatches", rows_checked, mismatches);
		if (mismatches == 0 && pending_rows == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
